### hdl/sha1bs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1bs_pkg
// Shared types, constants and round functions for the byte-stream SHA-1 unit.
// ---------------------------------------------------------------------------
package sha1bs_pkg;

	// initial hash words
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	// round constants
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	// padding
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] BLK_LAST = 6'd63;
	localparam logic [6:0] RND_LAST = 7'd79;

	// operations of the compression core
	typedef enum logic [2:0] {
		CORE_NOP,
		CORE_BYTE,
		CORE_ROUND,
		CORE_ADD,
		CORE_INIT
	} core_op_t;

	typedef struct packed {
		core_op_t    op;
		logic [7:0]  data;
		logic [6:0]  rnd;
	} core_cmd_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_DONE
	} state_t;

	// round-dependent boolean function
	function automatic logic [31:0] round_fn(input logic [6:0] rnd, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] res;
		if (rnd < 7'd20) begin
			res = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			res = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			res = (b & c) | (b & d) | (c & d);
		end else begin
			res = b ^ c ^ d;
		end
		return res;
	endfunction

	// round-dependent additive constant
	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] res;
		if (rnd < 7'd20) begin
			res = K0;
		end else if (rnd < 7'd40) begin
			res = K1;
		end else if (rnd < 7'd60) begin
			res = K2;
		end else begin
			res = K3;
		end
		return res;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

endpackage

### hdl/sha1_byte_stream_hash_unit.sv
`timescale 1ns / 1ps
// Flow: a word that does not fill a block is taken while idle; a word that fills
// the 64-byte block starts 80 rounds on the single round unit and one final add.
// An ending word then feeds 9 to 72 padding bytes at one per cycle, with one or two
// compressions among them; the digest is registered once the output register is free.
// No word is taken while a block is compressed or padded; the round unit sets throughput.
// Reset: asynchronous, active low; hash words to the initial values, byte count to zero.
// ---------------------------------------------------------------------------
// sha1_byte_stream_hash_unit
// Byte-stream SHA-1: buffers bytes in the message window, pads on request and
// returns the 160-bit digest through a registered output.
// ---------------------------------------------------------------------------
module sha1_byte_stream_hash_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        ends_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_high,
	output logic [63:0] digest_middle,
	output logic [31:0] digest_low
);

	sha1bs_pkg::state_t    state_q, state_d;
	sha1bs_pkg::core_cmd_t cmd;
	logic [159:0]          digest;
	logic [63:0]           cnt_q;
	logic [63:0]           len_q;
	logic [63:0]           cnt_inc;
	logic [6:0]            rnd_q;
	logic                  first_q;
	logic                  lenph_q;
	logic                  pad_q;
	logic                  out_valid_q;
	logic [63:0]           dig_high_q, dig_mid_q;
	logic [31:0]           dig_low_q;
	logic [7:0]            pad_byte;
	logic                  accept;
	logic                  finish;

	assign accept  = in_valid && in_ready;
	assign cnt_inc = cnt_q + {63'd0, has_byte};

	// padding byte: marker, zeros, then big-endian bit length
	always_comb begin
		if (first_q) begin
			pad_byte = sha1bs_pkg::PAD_MARK;
		end else if (lenph_q || cnt_q[5:0] == sha1bs_pkg::LEN_POS) begin
			pad_byte = len_q[{~cnt_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	sha1bs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.digest (digest)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1bs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and core commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		finish   = 1'b0;
		cmd.op   = sha1bs_pkg::CORE_NOP;
		cmd.data = pad_byte;
		cmd.rnd  = rnd_q;
		unique case (state_q)
			sha1bs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (has_byte) begin
						cmd.op   = sha1bs_pkg::CORE_BYTE;
						cmd.data = data_byte;
						if (cnt_q[5:0] == sha1bs_pkg::BLK_LAST) begin
							state_d = sha1bs_pkg::ST_ROUND;
						end else if (ends_message) begin
							state_d = sha1bs_pkg::ST_PAD;
						end
					end else if (ends_message) begin
						state_d = sha1bs_pkg::ST_PAD;
					end
				end
			end
			sha1bs_pkg::ST_PAD: begin
				cmd.op = sha1bs_pkg::CORE_BYTE;
				if (cnt_q[5:0] == sha1bs_pkg::BLK_LAST) begin
					state_d = sha1bs_pkg::ST_ROUND;
				end
			end
			sha1bs_pkg::ST_ROUND: begin
				cmd.op = sha1bs_pkg::CORE_ROUND;
				if (rnd_q == sha1bs_pkg::RND_LAST) begin
					state_d = sha1bs_pkg::ST_ADD;
				end
			end
			sha1bs_pkg::ST_ADD: begin
				cmd.op = sha1bs_pkg::CORE_ADD;
				if (lenph_q) begin
					state_d = sha1bs_pkg::ST_DONE;
				end else if (pad_q) begin
					state_d = sha1bs_pkg::ST_PAD;
				end else begin
					state_d = sha1bs_pkg::ST_IDLE;
				end
			end
			sha1bs_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = sha1bs_pkg::CORE_INIT;
					finish  = 1'b1;
					state_d = sha1bs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1bs_pkg::ST_IDLE;
			end
		endcase
	end

	// byte count, round counter and padding progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rnd_q   <= '0;
			first_q <= 1'b0;
			lenph_q <= 1'b0;
			pad_q   <= 1'b0;
		end else begin
			if (finish) begin
				cnt_q <= '0;
			end else if (cmd.op == sha1bs_pkg::CORE_BYTE) begin
				cnt_q <= cnt_q + 64'd1;
			end
			if (state_q == sha1bs_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 7'd1;
			end else begin
				rnd_q <= '0;
			end
			if (accept) begin
				pad_q   <= ends_message;
				first_q <= 1'b1;
				lenph_q <= 1'b0;
			end else if (finish) begin
				pad_q   <= 1'b0;
				lenph_q <= 1'b0;
			end else if (state_q == sha1bs_pkg::ST_PAD) begin
				if (first_q) begin
					first_q <= 1'b0;
				end else if (cnt_q[5:0] == sha1bs_pkg::LEN_POS) begin
					lenph_q <= 1'b1;
				end
			end
		end
	end

	// bit length of the message, latched when the ending word is taken
	always_ff @(posedge clk) begin
		if (accept && ends_message) begin
			len_q <= {cnt_inc[60:0], 3'b000};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			dig_high_q <= digest[159:96];
			dig_mid_q  <= digest[95:32];
			dig_low_q  <= digest[31:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign digest_high   = dig_high_q;
	assign digest_middle = dig_mid_q;
	assign digest_low    = dig_low_q;

`ifndef SYNTHESIS
	// compression starts only on a full block
	a_round_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1bs_pkg::ST_ROUND && rnd_q == 7'd0) |-> cnt_q[5:0] == 6'd0)
		else $error("compression started on a partial block");

	// final add follows the last round
	a_add_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1bs_pkg::ST_ADD) |->
		($past(state_q) == sha1bs_pkg::ST_ROUND && $past(rnd_q) == sha1bs_pkg::RND_LAST))
		else $error("final add without a full round sequence");

	// length bytes occupy the block tail only
	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		lenph_q |-> (cnt_q[5:3] == 3'b111 || cnt_q[5:0] == 6'd0))
		else $error("length bytes outside the block tail");

	// digest only after a padded, block-aligned message
	a_done_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1bs_pkg::ST_DONE) |-> (lenph_q && cnt_q[5:0] == 6'd0))
		else $error("digest produced before padding completed");
`endif

endmodule

### hdl/sha1bs_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1bs_core
// Compression datapath: 16-word message window, working variables, one
// shared round unit and the five hash words.
// ---------------------------------------------------------------------------
module sha1bs_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1bs_pkg::core_cmd_t cmd,
	output logic [159:0]          digest
);

	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [511:0] win_q;
	logic [31:0]  w0, w2, w8, w13;
	logic [31:0]  w_new;
	logic [31:0]  nxt;

	// window taps, word 0 is the current schedule word
	assign w0  = win_q[511 -: 32];
	assign w2  = win_q[511 - 32 * 2 -: 32];
	assign w8  = win_q[511 - 32 * 8 -: 32];
	assign w13 = win_q[511 - 32 * 13 -: 32];
	assign w_new = sha1bs_pkg::rotl(w13 ^ w8 ^ w2 ^ w0, 1);

	// shared round adder
	assign nxt = sha1bs_pkg::rotl(a_q, 5) + sha1bs_pkg::round_fn(cmd.rnd, b_q, c_q, d_q)
		+ e_q + sha1bs_pkg::round_k(cmd.rnd) + w0;

	// hash words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= sha1bs_pkg::IV0;
			h_q[1] <= sha1bs_pkg::IV1;
			h_q[2] <= sha1bs_pkg::IV2;
			h_q[3] <= sha1bs_pkg::IV3;
			h_q[4] <= sha1bs_pkg::IV4;
		end else begin
			unique case (cmd.op)
				sha1bs_pkg::CORE_INIT: begin
					h_q[0] <= sha1bs_pkg::IV0;
					h_q[1] <= sha1bs_pkg::IV1;
					h_q[2] <= sha1bs_pkg::IV2;
					h_q[3] <= sha1bs_pkg::IV3;
					h_q[4] <= sha1bs_pkg::IV4;
				end
				sha1bs_pkg::CORE_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end
				default: begin
				end
			endcase
		end
	end

	// window and working variables; loading a byte also primes a..e
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			sha1bs_pkg::CORE_BYTE: begin
				win_q <= {win_q[503:0], cmd.data};
				a_q   <= h_q[0];
				b_q   <= h_q[1];
				c_q   <= h_q[2];
				d_q   <= h_q[3];
				e_q   <= h_q[4];
			end
			sha1bs_pkg::CORE_ROUND: begin
				win_q <= {win_q[479:0], w_new};
				a_q   <= nxt;
				b_q   <= a_q;
				c_q   <= sha1bs_pkg::rotl(b_q, 30);
				d_q   <= c_q;
				e_q   <= d_q;
			end
			default: begin
			end
		endcase
	end

	assign digest = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

endmodule
